// ===== design/quadratic_root_solver_core_macros.svh =====
// ----------------------------------------------------------------------------
// quadratic root solver assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef QUADRATIC_ROOT_SOLVER_CORE_MACROS_SVH
`define QUADRATIC_ROOT_SOLVER_CORE_MACROS_SVH

// same-cycle implication, off during reset
`define QRS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define QRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/qrs_pkg.sv =====
// ----------------------------------------------------------------------------
// quadratic root solver package
// shared control struct, count codes and result widths
// ----------------------------------------------------------------------------
package qrs_pkg;

  localparam int ROOT_BITS  = 33;
  localparam int COUNT_BITS = 3;
  // count, two roots, padded to whole bytes
  localparam int OUT_W = ((COUNT_BITS + 2 * ROOT_BITS + 7) / 8) * 8;

  localparam logic [COUNT_BITS-1:0] CNT_NONE  = 3'd0;
  localparam logic [COUNT_BITS-1:0] CNT_ONE   = 3'd1;
  localparam logic [COUNT_BITS-1:0] CNT_TWO   = 3'd2;
  localparam logic [COUNT_BITS-1:0] CNT_INF   = 3'd3;
  localparam logic [COUNT_BITS-1:0] CNT_NOSOL = 3'd4;

  typedef struct packed {
    logic                  valid;
    logic                  is_quadratic;
    logic [COUNT_BITS-1:0] root_count;
  } ctl_t;

endpackage

// ===== design/qrs_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// square root cell
// one restoring digit of the fixed point square root per cycle while the pipe advances
// ----------------------------------------------------------------------------
module qrs_sqrt_cell #(
  parameter int DW  = 34,
  parameter int RW  = 33,
  parameter int SBW = 110
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             adv,
  input  qrs_pkg::ctl_t    ctl_i,
  input  logic [DW-1:0]    rad_i,
  input  logic [RW-1:0]    root_i,
  input  logic [RW+1:0]    rem_i,
  input  logic [SBW-1:0]   sb_i,
  output qrs_pkg::ctl_t    ctl_o,
  output logic [DW-1:0]    rad_o,
  output logic [RW-1:0]    root_o,
  output logic [RW+1:0]    rem_o,
  output logic [SBW-1:0]   sb_o
);
  import qrs_pkg::*;

  logic [RW+3:0] remx;
  logic [RW+3:0] trial;
  logic [RW+3:0] diff;
  logic          ge;

  always_comb begin
    remx  = {rem_i, rad_i[DW-1:DW-2]};
    trial = {2'b00, root_i, 2'b01};
    diff  = remx - trial;
    ge    = (remx >= trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_o <= '0;
    end else if (adv) begin
      ctl_o <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rad_o  <= {rad_i[DW-3:0], 2'b00};
      root_o <= {root_i[RW-2:0], ge};
      rem_o  <= ge ? diff[RW+1:0] : remx[RW+1:0];
      sb_o   <= sb_i;
    end
  end

endmodule

// ===== design/qrs_div_cell.sv =====
// ----------------------------------------------------------------------------
// divider cell
// one restoring quotient bit per cycle while the pipe advances, for both root lanes
// ----------------------------------------------------------------------------
module qrs_div_cell #(
  parameter int NW = 34,
  parameter int DM = 17
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  qrs_pkg::ctl_t       ctl_i,
  input  logic [1:0][NW-1:0]  num_i,
  input  logic [1:0][DM-1:0]  den_i,
  input  logic [1:0][DM-1:0]  rem_i,
  input  logic [1:0][NW-1:0]  quot_i,
  input  logic [1:0]          neg_i,
  output qrs_pkg::ctl_t       ctl_o,
  output logic [1:0][NW-1:0]  num_o,
  output logic [1:0][DM-1:0]  den_o,
  output logic [1:0][DM-1:0]  rem_o,
  output logic [1:0][NW-1:0]  quot_o,
  output logic [1:0]          neg_o
);
  import qrs_pkg::*;

  logic [1:0][DM:0]   remx;
  logic [1:0][DM:0]   diff;
  logic [1:0]         ge;
  logic [1:0][DM-1:0] rem_next;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      remx[l]     = {rem_i[l], num_i[l][NW-1]};
      diff[l]     = remx[l] - {1'b0, den_i[l]};
      ge[l]       = (remx[l] >= {1'b0, den_i[l]});
      rem_next[l] = ge[l] ? diff[l][DM-1:0] : remx[l][DM-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_o <= '0;
    end else if (adv) begin
      ctl_o <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < 2; l++) begin
        num_o[l]  <= {num_i[l][NW-2:0], 1'b0};
        quot_o[l] <= {quot_i[l][NW-2:0], ge[l]};
      end
      den_o <= den_i;
      rem_o <= rem_next;
      neg_o <= neg_i;
    end
  end

endmodule

// ===== design/quadratic_root_solver_core.sv =====
// ----------------------------------------------------------------------------
// quadratic root solver core
// solves a*x^2 + b*x + c = 0, roots in signed fixed point
// ----------------------------------------------------------------------------
//  channel  | direction | payload
//  s_*      | in        | coef_a, coef_b, coef_c per request
//  m_*      | out       | root_count, root_first, root_second, tuser is_quadratic
//
//  one request per cycle while the output side does not stall, fully pipelined
//  result path: coefficient and product register, case split register, the
//  square root cell chain (one digit per cell), numerator magnitude register,
//  the divider cell chain (one quotient bit per cell) and the output register
//  whole pipe advances while the output register is empty or being taken
//  synchronous reset clears all valid flags, data registers are not reset
// ----------------------------------------------------------------------------
module quadratic_root_solver_core #(
  parameter int COEF_BITS = 16,
  parameter int FRAC_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  // coef_a, coef_b, coef_c from bit 0, zero padded
  input  logic [((3*COEF_BITS+7)/8)*8-1:0]       s_tdata,
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  // root_count, root_first, root_second from bit 0, zero padded
  output logic [qrs_pkg::OUT_W-1:0]              m_tdata,
  // is_quadratic
  output logic                                   m_tuser
);
  import qrs_pkg::*;

  localparam int CB  = COEF_BITS;
  localparam int F   = FRAC_BITS;
  localparam int DW  = 2 * CB + 2;          // signed discriminant, even for digit pairs
  localparam int RW  = CB + 1 + F;          // square root result bits
  localparam int NS  = CB + F + 3;          // signed numerator
  localparam int NW  = CB + F + 2;          // numerator magnitude, quotient bits
  localparam int DS  = CB + 2;              // signed denominator
  localparam int DM  = CB + 1;              // denominator magnitude
  localparam int SBW = 2 * NS + 2 * DS;     // numerator bases and denominators
  localparam int QS  = NW + 1;
  localparam int EW  = ((QS > ROOT_BITS) ? QS : ROOT_BITS) + 1;
  localparam int PADW = OUT_W - COUNT_BITS - 2 * ROOT_BITS;

  localparam logic signed [EW-1:0] RMAX =
    {{(EW-ROOT_BITS+1){1'b0}}, {(ROOT_BITS-1){1'b1}}};
  localparam logic signed [EW-1:0] RMIN =
    {{(EW-ROOT_BITS+1){1'b1}}, {(ROOT_BITS-1){1'b0}}};

  // global advance: output register free or being emptied
  logic adv;
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  // input split
  logic signed [CB-1:0] in_a, in_b, in_c;
  assign in_a = s_tdata[CB-1:0];
  assign in_b = s_tdata[2*CB-1:CB];
  assign in_c = s_tdata[3*CB-1:2*CB];

  // stage 0: register coefficients and products
  logic                   v0;
  logic signed [CB-1:0]   a0, b0, c0;
  logic signed [2*CB-1:0] bb0, ac0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (adv) begin
      v0 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a0  <= in_a;
      b0  <= in_b;
      c0  <= in_c;
      bb0 <= in_b * in_b;
      ac0 <= in_a * in_c;
    end
  end

  // stage 1: discriminant and case split
  logic signed [DW-1:0]   disc;
  logic signed [NS-1:0]   neg_b_sc, neg_c_sc;
  logic signed [DS-1:0]   two_a;
  logic signed [NS-1:0]   base1, base2;
  logic signed [DS-1:0]   den1, den2;
  logic [DW-1:0]          rad;
  logic [COUNT_BITS-1:0]  cnt;

  always_comb begin
    disc     = DW'(bb0) - (DW'(ac0) <<< 2);
    neg_b_sc = (-NS'(b0)) <<< F;
    neg_c_sc = (-NS'(c0)) <<< F;
    two_a    = DS'(a0) <<< 1;
    cnt      = CNT_NONE;
    base1    = '0;
    base2    = '0;
    den1     = DS'(1);
    den2     = DS'(1);
    rad      = '0;
    priority if (a0 == '0) begin
      if (b0 == '0) begin
        cnt = (c0 == '0) ? CNT_INF : CNT_NOSOL;
      end else begin
        // linear: -c/b
        cnt   = CNT_ONE;
        base1 = neg_c_sc;
        den1  = DS'(b0);
      end
    end else if (c0 == '0) begin
      // zero root, and -b/a in the second place
      if (b0 == '0) begin
        cnt = CNT_ONE;
      end else begin
        cnt   = CNT_TWO;
        base2 = neg_b_sc;
        den2  = DS'(a0);
      end
    end else if (disc < 0) begin
      cnt = CNT_NONE;
    end else if (disc == '0) begin
      // double root, square root stays zero
      cnt   = CNT_ONE;
      base1 = neg_b_sc;
      den1  = two_a;
    end else begin
      cnt   = CNT_TWO;
      base1 = neg_b_sc;
      base2 = neg_b_sc;
      den1  = two_a;
      den2  = two_a;
      rad   = disc;
    end
  end

  ctl_t           ctl_q  [0:RW];
  logic [DW-1:0]  rad_q  [0:RW];
  logic [RW-1:0]  root_q [0:RW];
  logic [RW+1:0]  rem_q  [0:RW];
  logic [SBW-1:0] sb_q   [0:RW];

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_q[0] <= '0;
    end else if (adv) begin
      ctl_q[0].valid        <= v0;
      ctl_q[0].is_quadratic <= (a0 != '0);
      ctl_q[0].root_count   <= cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rad_q[0] <= rad;
      sb_q[0]  <= {base1, base2, den1, den2};
    end
  end

  assign root_q[0] = '0;
  assign rem_q[0]  = '0;

  // square root chain, most significant digit first
  for (genvar g = 0; g < RW; g++) begin : g_sqrt
    qrs_sqrt_cell #(.DW(DW), .RW(RW), .SBW(SBW)) u_cell (
      .clk    (clk),
      .rst    (rst),
      .adv    (adv),
      .ctl_i  (ctl_q[g]),
      .rad_i  (rad_q[g]),
      .root_i (root_q[g]),
      .rem_i  (rem_q[g]),
      .sb_i   (sb_q[g]),
      .ctl_o  (ctl_q[g+1]),
      .rad_o  (rad_q[g+1]),
      .root_o (root_q[g+1]),
      .rem_o  (rem_q[g+1]),
      .sb_o   (sb_q[g+1])
    );
  end

  // numerators, magnitudes and quotient signs
  logic signed [NS-1:0]  sb_base1, sb_base2, sroot, num1, num2;
  logic signed [DS-1:0]  sb_den1, sb_den2;
  logic [1:0][NS-1:0]    num_abs;
  logic [1:0][DS-1:0]    den_abs;
  logic [1:0]            lane_neg;

  always_comb begin
    {sb_base1, sb_base2, sb_den1, sb_den2} = sb_q[RW];
    sroot      = NS'(root_q[RW]);
    num1       = sb_base1 + sroot;
    num2       = sb_base2 - sroot;
    num_abs[0] = num1[NS-1] ? -num1 : num1;
    num_abs[1] = num2[NS-1] ? -num2 : num2;
    den_abs[0] = sb_den1[DS-1] ? -sb_den1 : sb_den1;
    den_abs[1] = sb_den2[DS-1] ? -sb_den2 : sb_den2;
    lane_neg   = {num2[NS-1] ^ sb_den2[DS-1], num1[NS-1] ^ sb_den1[DS-1]};
  end

  ctl_t               ctl_d  [0:NW];
  logic [1:0][NW-1:0] num_d  [0:NW];
  logic [1:0][DM-1:0] den_d  [0:NW];
  logic [1:0][DM-1:0] rem_d  [0:NW];
  logic [1:0][NW-1:0] quot_d [0:NW];
  logic [1:0]         neg_d  [0:NW];

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_d[0] <= '0;
    end else if (adv) begin
      ctl_d[0] <= ctl_q[RW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < 2; l++) begin
        num_d[0][l] <= num_abs[l][NW-1:0];
        den_d[0][l] <= den_abs[l][DM-1:0];
      end
      neg_d[0] <= lane_neg;
    end
  end

  assign rem_d[0]  = '0;
  assign quot_d[0] = '0;

  // divider chain, both roots side by side
  for (genvar g = 0; g < NW; g++) begin : g_div
    qrs_div_cell #(.NW(NW), .DM(DM)) u_cell (
      .clk    (clk),
      .rst    (rst),
      .adv    (adv),
      .ctl_i  (ctl_d[g]),
      .num_i  (num_d[g]),
      .den_i  (den_d[g]),
      .rem_i  (rem_d[g]),
      .quot_i (quot_d[g]),
      .neg_i  (neg_d[g]),
      .ctl_o  (ctl_d[g+1]),
      .num_o  (num_d[g+1]),
      .den_o  (den_d[g+1]),
      .rem_o  (rem_d[g+1]),
      .quot_o (quot_d[g+1]),
      .neg_o  (neg_d[g+1])
    );
  end

  // sign restore and saturation to the root field
  logic signed [EW-1:0]       qext [0:1];
  logic signed [EW-1:0]       qsat [0:1];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      qext[l] = EW'(quot_d[NW][l]);
      if (neg_d[NW][l]) begin
        qext[l] = -qext[l];
      end
      if (qext[l] > RMAX) begin
        qsat[l] = RMAX;
      end else if (qext[l] < RMIN) begin
        qsat[l] = RMIN;
      end else begin
        qsat[l] = qext[l];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= ctl_d[NW].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= {{PADW{1'b0}}, qsat[1][ROOT_BITS-1:0], qsat[0][ROOT_BITS-1:0],
                  ctl_d[NW].root_count};
      m_tuser <= ctl_d[NW].is_quadratic;
    end
  end

endmodule

// ===== design/qrs_checker.sv =====
// ----------------------------------------------------------------------------
// quadratic root solver port checker
// result consistency and flow checks seen at the ports
// ----------------------------------------------------------------------------
`include "quadratic_root_solver_core_macros.svh"

module qrs_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      s_tready,
  input logic                      m_tvalid,
  input logic                      m_tready,
  input logic [qrs_pkg::OUT_W-1:0] m_tdata,
  input logic                      m_tuser
);
  import qrs_pkg::*;

  logic [COUNT_BITS-1:0] cnt;
  logic [ROOT_BITS-1:0]  r1, r2;

  assign cnt = m_tdata[COUNT_BITS-1:0];
  assign r1  = m_tdata[COUNT_BITS+ROOT_BITS-1:COUNT_BITS];
  assign r2  = m_tdata[COUNT_BITS+2*ROOT_BITS-1:COUNT_BITS+ROOT_BITS];

  // held result stays put
  `QRS_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

  // empty output register never blocks requests
  `QRS_ASSERT_NOW(a_ready, !m_tvalid, s_tready, "input blocked with empty output")

  // count code matches equation kind
  `QRS_ASSERT_NOW(a_kind, m_tvalid, (m_tuser && (cnt == CNT_NONE || cnt == CNT_ONE || cnt == CNT_TWO)) || (!m_tuser && (cnt == CNT_ONE || cnt == CNT_INF || cnt == CNT_NOSOL)), "count code does not fit equation kind")

  // unused root fields read zero
  `QRS_ASSERT_NOW(a_unused, m_tvalid && cnt != CNT_TWO, (r2 == '0) && (cnt == CNT_ONE || r1 == '0), "unused root not zero")

endmodule

bind quadratic_root_solver_core qrs_checker u_qrs_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

// ===== verif/quadratic_root_solver_core_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadratic root solver checker
// watches both streams, works out the roots of every accepted request and
// compares each returned result field by field, oldest first
// ----------------------------------------------------------------------------
module quadratic_root_solver_core_chk (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  input  logic                      s_tready,
  input  logic [47:0]               s_tdata,
  input  logic                      m_tvalid,
  input  logic                      m_tready,
  input  logic [qrs_pkg::OUT_W-1:0] m_tdata,
  input  logic                      m_tuser,
  output int                        fail_cnt,
  output int                        pending_cnt
);
  import qrs_pkg::*;

  localparam int FRAC = 16;

  typedef struct packed {
    logic                  is_quadratic;
    logic [COUNT_BITS-1:0] root_count;
    logic [ROOT_BITS-1:0]  root_first;
    logic [ROOT_BITS-1:0]  root_second;
  } roots_t;

  roots_t roots_q[$];

  assign pending_cnt = roots_q.size();

  // digit-by-digit square root of 4*q + r, then FRAC more digit pairs
  function automatic longint unsigned disc_sqrt(longint unsigned q, longint unsigned r);
    longint unsigned root, rem, trial, pr;
    root = 0;
    rem  = 0;
    for (int i = 32 + FRAC; i >= 0; i--) begin
      if (i > FRAC) pr = (q >> (2 * (i - FRAC - 1))) & 3;
      else if (i == FRAC) pr = r;
      else pr = 0;
      rem   = (rem << 2) | pr;
      trial = (root << 2) | 1;
      if (rem >= trial) begin
        rem  = rem - trial;
        root = (root << 1) | 1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  function automatic logic [ROOT_BITS-1:0] clip_root(longint r);
    if (r > 64'sd4294967295) r = 64'sd4294967295;
    if (r < -64'sd4294967296) r = -64'sd4294967296;
    return r[ROOT_BITS-1:0];
  endfunction

  function automatic roots_t solve_quadratic(logic [47:0] d);
    longint a, b, c, q, s, r1, r2, one;
    longint unsigned b2, lo;
    roots_t res;
    a   = longint'($signed(d[15:0]));
    b   = longint'($signed(d[31:16]));
    c   = longint'($signed(d[47:32]));
    one = longint'(1) << FRAC;
    r1  = 0;
    r2  = 0;
    res = '0;
    if (a == 0) begin
      if (b == 0) begin
        res.root_count = (c == 0) ? CNT_INF : CNT_NOSOL;
      end else begin
        res.root_count = CNT_ONE;
        r1 = (c == 0) ? 0 : (-c * one) / b;
      end
    end else begin
      res.is_quadratic = 1'b1;
      if (c == 0) begin
        if (b == 0) res.root_count = CNT_ONE;
        else begin
          res.root_count = CNT_TWO;
          r2 = (-b * one) / a;
        end
      end else begin
        b2 = longint'(b * b);
        q  = longint'(b2 >> 2) - a * c;
        lo = b2 & 3;
        if (q < 0) res.root_count = CNT_NONE;
        else if (q == 0 && lo == 0) begin
          res.root_count = CNT_ONE;
          r1 = (-b * one) / (2 * a);
        end else begin
          s  = longint'(disc_sqrt(q, lo));
          res.root_count = CNT_TWO;
          r1 = (-b * one + s) / (2 * a);
          r2 = (-b * one - s) / (2 * a);
        end
      end
    end
    res.root_first  = clip_root(r1);
    res.root_second = clip_root(r2);
    return res;
  endfunction

  always @(posedge clk) begin
    roots_t want;
    int     errs;
    errs = 0;
    if (rst) begin
      fail_cnt <= 0;
      roots_q.delete();
    end else begin
      if (s_tvalid && s_tready) roots_q.push_back(solve_quadratic(s_tdata));
      if (m_tvalid && m_tready) begin
        if (roots_q.size() == 0) begin
          $error("result with no request waiting");
          errs++;
        end else begin
          want = roots_q.pop_front();
          if (m_tuser !== want.is_quadratic) begin
            $error("is_quadratic: expected %0d actual %0d", want.is_quadratic, m_tuser);
            errs++;
          end
          if (m_tdata[2:0] !== want.root_count) begin
            $error("root_count: expected %0d actual %0d", want.root_count, m_tdata[2:0]);
            errs++;
          end
          if (m_tdata[35:3] !== want.root_first) begin
            $error("root_first: expected %h actual %h", want.root_first, m_tdata[35:3]);
            errs++;
          end
          if (m_tdata[68:36] !== want.root_second) begin
            $error("root_second: expected %h actual %h", want.root_second, m_tdata[68:36]);
            errs++;
          end
        end
      end
      if (errs != 0) fail_cnt <= fail_cnt + errs;
    end
  end

endmodule

// ===== verif/quadratic_root_solver_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadratic root solver testbench
// directed corner coefficients then random requests with bursty gaps on both
// sides; the checker predicts and compares, this top gives the verdict
// ----------------------------------------------------------------------------
module quadratic_root_solver_core_tb;
  import qrs_pkg::*;

  localparam int LATENCY   = 71;
  localparam int CYCLE_CAP = 400000;
  localparam int N_RANDOM  = 830;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [47:0]      s_tdata = '0;   // coef_a, coef_b, coef_c from bit 0
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;        // root_count, root_first, root_second
  logic             m_tuser;        // is_quadratic
  int               fail_cnt;
  int               pending_cnt;
  int               cycle_cnt = 0;
  bit               calm = 1'b0;    // no idling in the closing stretch

  always #4 clk = ~clk;

  quadratic_root_solver_core u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  quadratic_root_solver_core_chk u_chk (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .fail_cnt(fail_cnt), .pending_cnt(pending_cnt)
  );

  // result side stalls in bursts
  always @(posedge clk) begin
    int hold;
    if (!rst) begin
      if (calm || $urandom_range(0, 3) != 0) m_tready <= 1'b1;
      else begin
        m_tready <= 1'b0;
        hold = $urandom_range(1, 10);
        repeat (hold) @(posedge clk);
        m_tready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_CAP) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // one request, held until taken
  task automatic send_coefs(logic [15:0] a, logic [15:0] b, logic [15:0] c);
    s_tvalid <= 1'b1;
    s_tdata  <= {c, b, a};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic idle_gap();
    int gap;
    if (!calm && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 10);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [15:0] pick_coef();
    case ($urandom_range(0, 5))
      0:       return 16'h0000;
      1:       return 16'(int'($urandom_range(0, 8)) - 4);
      2:       return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      3:       return 16'(int'($urandom_range(0, 400)) - 200);
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic [15:0] a, b, c;
    int k;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // linear: infinite, no solution, single root, zero root
    send_coefs(16'd0, 16'd0, 16'd0);
    send_coefs(16'd0, 16'd0, 16'd5);
    send_coefs(16'd0, 16'd3, 16'hfff9);
    send_coefs(16'd0, 16'h8000, 16'd0);
    send_coefs(16'd0, 16'd1, 16'h8000);
    send_coefs(16'd0, 16'hffff, 16'h7fff);
    // zero constant: lone zero root and zero plus -b/a
    send_coefs(16'd7, 16'd0, 16'd0);
    send_coefs(16'h8000, 16'h7fff, 16'd0);
    send_coefs(16'd1, 16'h8000, 16'd0);
    // negative, zero and positive discriminant
    send_coefs(16'd1, 16'd0, 16'd1);
    send_coefs(16'd1, 16'd2, 16'd1);
    send_coefs(16'hffff, 16'd4, 16'hfffc);
    send_coefs(16'd1, 16'd0, 16'hffff);
    send_coefs(16'd1, 16'd3, 16'd2);
    send_coefs(16'd1, 16'h8000, 16'h8000);
    send_coefs(16'h8000, 16'h8000, 16'h7fff);
    send_coefs(16'h7fff, 16'h7fff, 16'h7fff);
    send_coefs(16'd1, 16'h8000, 16'h7fff);
    send_coefs(16'h8000, 16'h7fff, 16'h8000);
    send_coefs(16'hffff, 16'hffff, 16'hffff);
    s_tvalid <= 1'b0;

    // hold off until the pipe has drained
    while (pending_cnt != 0) @(posedge clk);

    for (k = 0; k < N_RANDOM; k++) begin
      if (k == N_RANDOM - 120) calm = 1'b1;
      a = pick_coef();
      b = pick_coef();
      c = pick_coef();
      if (k % 5 == 0) begin
        // perfect square b^2 = 4ac: repeated root
        a = 16'(int'($urandom_range(1, 60)) * ($urandom_range(0, 1) ? 1 : -1));
        c = 16'(int'($urandom_range(1, 60)) * ($urandom_range(0, 1) ? 1 : -1));
        c = (($signed(a) > 0) == ($signed(c) > 0)) ? c : -c;
        b = 16'(2 * int'($sqrt(real'($signed(a) * $signed(c)))));
        if (int'($signed(b)) * int'($signed(b)) != 4 * $signed(a) * $signed(c)) b = 16'd2;
        if (b == 16'd2) begin
          a = 16'd1;
          c = 16'd1;
        end
        if ($urandom_range(0, 1)) b = -b;
      end
      send_coefs(a, b, c);
      idle_gap();
    end
    s_tvalid <= 1'b0;

    while (pending_cnt != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (fail_cnt == 0 && pending_cnt == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule
